>>> hw/rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg - shared definitions for the masked byte pattern search
// Widths, register indexes and the types passed between the window
// chain and its cells.
// ----------------------------------------------------------------------------
package mbps_pkg;

    // Window depth (number of cells); pattern bytes exist for positions 0..15
    localparam int MaxPatternBytes = 16;
    localparam int PatternBytes    = 16;
    localparam int PatIdxW         = $clog2(PatternBytes);

    localparam int LenW      = 5;
    localparam int AddrW     = 64;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 64;
    localparam int CareW     = 16;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgPatternLow    = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgPatternHigh   = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgCareMask      = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgPatternLength = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgBaseAddress   = 3'd4;

    typedef logic [PatternBytes-1:0][7:0] pattern_t;

    // Shift and clear commands common to every cell
    typedef struct packed {
        logic advance;
        logic flush;
    } cell_ctrl_t;

    // Expected byte of one cell and whether it must match
    typedef struct packed {
        logic [7:0] want;
        logic       care;
    } cell_exp_t;

endpackage

>>> hw/rtl/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell - one byte of the search window
// Holds one byte, hands it to the next cell on every accepted word and
// compares the byte it takes in against its expected byte.
// ----------------------------------------------------------------------------
module mbps_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mbps_pkg::cell_ctrl_t   ctrl,
    input  mbps_pkg::cell_exp_t    exp_i,
    input  logic [7:0]             din,
    output logic [7:0]             dout,
    output logic                   hit
);

    logic [7:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else if (ctrl.flush) begin
            byte_reg <= '0;
        end else if (ctrl.advance) begin
            byte_reg <= din;
        end
    end

    // Compare the byte entering this cell, i.e. the window after the shift
    assign hit  = !exp_i.care || (din == exp_i.want);
    assign dout = byte_reg;

endmodule

>>> hw/rtl/mbps_window.sv
// ----------------------------------------------------------------------------
// mbps_window - row of window cells with per-cell pattern alignment
// Cell k holds the byte of age k; for a pattern of length L it checks
// pattern position L-1-k. The match is the AND of all cell hits.
// ----------------------------------------------------------------------------
module mbps_window (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mbps_pkg::cell_ctrl_t         ctrl,
    input  logic [7:0]                   din,
    input  mbps_pkg::pattern_t           pattern,
    input  logic [mbps_pkg::CareW-1:0]   care_mask,
    input  logic [mbps_pkg::LenW-1:0]    pattern_length,
    output logic                         match
);

    logic [mbps_pkg::MaxPatternBytes:0][7:0]  link;
    logic [mbps_pkg::MaxPatternBytes-1:0]     hits;

    assign link[0] = din;

    for (genvar g = 0; g < mbps_pkg::MaxPatternBytes; g++) begin : g_cell
        localparam logic [mbps_pkg::LenW:0] CellPos = (mbps_pkg::LenW + 1)'(g);

        logic [mbps_pkg::LenW:0]      diff;
        logic [mbps_pkg::PatIdxW-1:0] pidx;
        logic                         in_win;
        logic                         pos_ok;
        mbps_pkg::cell_exp_t          exp_c;

        always_comb begin
            diff   = {1'b0, pattern_length} - CellPos - (mbps_pkg::LenW + 1)'(1);
            pidx   = diff[mbps_pkg::PatIdxW-1:0];
            in_win = {1'b0, pattern_length} > CellPos;
            // positions beyond the stored pattern are wildcards
            pos_ok = diff < (mbps_pkg::LenW + 1)'(mbps_pkg::PatternBytes);
            exp_c.want = pattern[pidx];
            exp_c.care = in_win && pos_ok && care_mask[pidx];
        end

        mbps_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .exp_i   (exp_c),
            .din     (link[g]),
            .dout    (link[g+1]),
            .hit     (hits[g])
        );
    end

    // Oldest cell output leaves the window unused
    logic unused_tail;
    assign unused_tail = ^link[mbps_pkg::MaxPatternBytes];

    assign match = &hits;

endmodule

>>> hw/rtl/masked_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_search - wildcard byte pattern search over a region
// Scans a region one byte per word and reports the first address at which a
// masked pattern of up to sixteen bytes matches, or not found at region end.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  s_data_byte, s_last_in_region
//  m_       out        m_valid / m_ready  m_found, m_match_address
//  cfg_     in         cfg_write          cfg_index, cfg_data
//
//  One byte is accepted every cycle while s_ready is high; a result for a byte
//  passes the match stage, then the base-address add stage, on its way to m_.
//  The window shift and compare of all cells is done in the accepting cycle.
//  Reset (aresetn low, synchronous) clears config, valid flags, window, count.
//  s_ready drops only when a result waits in the match stage and the output
//  word is held by m_ready low; then any byte stalls, result or not.
//
module masked_byte_pattern_search (
    input  logic                            aclk,
    input  logic                            aresetn,
    // byte stream
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_data_byte,
    input  logic                            s_last_in_region,
    // results
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_found,
    output logic [mbps_pkg::AddrW-1:0]      m_match_address,
    // configuration writes
    input  logic                            cfg_write,
    input  logic [mbps_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [mbps_pkg::CfgDataW-1:0]   cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [63:0]                   pattern_low_reg;
    logic [63:0]                   pattern_high_reg;
    logic [mbps_pkg::CareW-1:0]    care_mask_reg;
    logic [mbps_pkg::LenW-1:0]     pattern_length_reg;
    logic [mbps_pkg::AddrW-1:0]    base_address_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '0;
            pattern_length_reg <= '0;
            base_address_reg   <= '0;
        end else if (cfg_write) begin
            case (cfg_index)
                mbps_pkg::CfgPatternLow:    pattern_low_reg    <= cfg_data;
                mbps_pkg::CfgPatternHigh:   pattern_high_reg   <= cfg_data;
                mbps_pkg::CfgCareMask:
                    care_mask_reg <= cfg_data[mbps_pkg::CareW-1:0];
                mbps_pkg::CfgPatternLength:
                    pattern_length_reg <= cfg_data[mbps_pkg::LenW-1:0];
                mbps_pkg::CfgBaseAddress:   base_address_reg   <= cfg_data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic                          accept;
    logic                          out_free;
    logic                          stage_move;

    logic                          res_valid_reg;
    logic                          res_found_reg;
    logic [mbps_pkg::AddrW-1:0]    res_offset_reg;

    logic                          m_valid_reg;
    logic                          m_found_reg;
    logic [mbps_pkg::AddrW-1:0]    m_addr_reg;

    // The output word may be replaced when empty or being taken
    assign out_free   = !m_valid_reg || m_ready;
    assign stage_move = res_valid_reg && out_free;
    // Take a byte whenever the match stage is empty or drains this cycle
    assign s_ready    = !res_valid_reg || out_free;
    assign accept     = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Window chain: shift on every accepted byte, clear after the last one
    // ------------------------------------------------------------------
    mbps_pkg::cell_ctrl_t  cell_ctrl;
    mbps_pkg::pattern_t    pattern;
    logic                  window_match;

    assign cell_ctrl.advance = accept;
    assign cell_ctrl.flush   = accept && s_last_in_region;
    assign pattern           = {pattern_high_reg, pattern_low_reg};

    mbps_window u_window (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (cell_ctrl),
        .din            (s_data_byte),
        .pattern        (pattern),
        .care_mask      (care_mask_reg),
        .pattern_length (pattern_length_reg),
        .match          (window_match)
    );

    // ------------------------------------------------------------------
    // Region state: byte count and match flag
    // ------------------------------------------------------------------
    logic [mbps_pkg::AddrW-1:0]    bytes_seen_reg;
    logic [mbps_pkg::AddrW-1:0]    bytes_seen_next;
    logic                          matched_reg;
    logic                          len_ok;
    logic                          window_full;
    logic                          hit_now;
    logic                          res_now;
    logic [mbps_pkg::AddrW-1:0]    offset_now;

    assign bytes_seen_next = bytes_seen_reg + mbps_pkg::AddrW'(1);

    // A zero length or one longer than the window never matches
    assign len_ok = (pattern_length_reg != '0) &&
                    ({1'b0, pattern_length_reg} <=
                     (mbps_pkg::LenW + 1)'(mbps_pkg::MaxPatternBytes));

    // Window holds at least pattern_length bytes, counting this byte
    assign window_full = (|bytes_seen_next[mbps_pkg::AddrW-1:mbps_pkg::LenW]) ||
                         (bytes_seen_next[mbps_pkg::LenW-1:0] >= pattern_length_reg);

    assign hit_now = !matched_reg && len_ok && window_full && window_match;

    // Either a first match or the end of a region with none
    assign res_now = hit_now || (s_last_in_region && !matched_reg);

    // Offset of the first matching byte: count after this byte minus length
    assign offset_now = bytes_seen_reg -
                        mbps_pkg::AddrW'(pattern_length_reg - mbps_pkg::LenW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg <= '0;
            matched_reg    <= 1'b0;
        end else if (accept) begin
            if (s_last_in_region) begin
                bytes_seen_reg <= '0;
                matched_reg    <= 1'b0;
            end else begin
                bytes_seen_reg <= bytes_seen_next;
                matched_reg    <= matched_reg || hit_now;
            end
        end
    end

    // ------------------------------------------------------------------
    // Match stage: hold the found flag and offset of a pending result
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (accept) begin
            res_valid_reg <= res_now;
        end else if (stage_move) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_now) begin
            res_found_reg  <= hit_now;
            res_offset_reg <= offset_now;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: add the base address and hold until taken
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stage_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_move) begin
            m_found_reg <= res_found_reg;
            m_addr_reg  <= res_found_reg ? (base_address_reg + res_offset_reg)
                                         : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_found         = m_found_reg;
    assign m_match_address = m_addr_reg;

endmodule

>>> hw/rtl/mbps_checker.sv
// ----------------------------------------------------------------------------
// mbps_checker - port-level checks for the masked byte pattern search
// Watches the result channel and input stalls over time.
// ----------------------------------------------------------------------------
module mbps_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_found,
    input  logic [mbps_pkg::AddrW-1:0]      m_match_address
);

    // Reset empties the result channel
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word present after reset");

    // A held result word keeps its contents
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) &&
                                $stable(m_match_address))
        else $error("result word changed while stalled");

    // Not-found results carry a zero address
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_match_address == '0)
        else $error("not-found result with nonzero address");

    // Input stalls only behind a held result word
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back-pressure");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_found         (m_found),
    .m_match_address (m_match_address)
);
